>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the project, fts_checker.
// Depends on nothing; the including module provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define FTS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent check that also holds across reset.
`define FTS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> hdl/fts_pkg.sv
// Shared types, constants and a function of the file type sniffer.
// Depends on nothing; used by fts_classify, file_type_sniffer, fts_checker and the bench.
package fts_pkg;

  localparam int HEADER_MIN = 8;
  localparam int TAR_WINDOW = 100;
  localparam int HDR_BYTES  = 16;
  localparam logic [6:0] COUNT_MAX = 7'd127;
  localparam logic [2:0] CLASS_BAD = 3'd7;

  typedef enum logic [4:0] {
    FMT_JPEG     = 5'd0,
    FMT_PNG      = 5'd1,
    FMT_GIF      = 5'd2,
    FMT_QT       = 5'd3,
    FMT_MP4      = 5'd4,
    FMT_M4A      = 5'd5,
    FMT_M4V      = 5'd6,
    FMT_MOBILE   = 5'd7,
    FMT_MKV      = 5'd8,
    FMT_MPA      = 5'd9,
    FMT_MPV      = 5'd10,
    FMT_VORBIS   = 5'd11,
    FMT_WAVE     = 5'd12,
    FMT_RIFFVID  = 5'd13,
    FMT_ASF      = 5'd14,
    FMT_ZIP      = 5'd15,
    FMT_RAR      = 5'd16,
    FMT_DEFLATE  = 5'd17,
    FMT_BLOCKZ   = 5'd18,
    FMT_PDF      = 5'd19,
    FMT_DOC      = 5'd20,
    FMT_DJVU     = 5'd21,
    FMT_BITMAP   = 5'd22,
    FMT_ARCHIVE  = 5'd23,
    FMT_TEXT     = 5'd24,
    FMT_UNKNOWN  = 5'd25
  } type_code_t;

  typedef enum logic [1:0] {
    VERDICT_TEXT    = 2'd0,
    VERDICT_PENDING = 2'd1,
    VERDICT_UNKNOWN = 2'd2,
    VERDICT_TAR     = 2'd3
  } verdict_t;

  // Number of continuation bytes a UTF-8 lead byte announces, or CLASS_BAD.
  function automatic logic [2:0] lead_class(input logic [7:0] b);
    logic [2:0] c;
    begin
      if (b == 8'h09 || b == 8'h0a || b == 8'h0d) c = 3'd0;
      else if (b < 8'h20 || b == 8'h7f) c = CLASS_BAD;
      else if (b < 8'h80) c = 3'd0;
      else if (b < 8'hc0) c = CLASS_BAD;
      else if (b < 8'he0) c = 3'd1;
      else if (b < 8'hf0) c = 3'd2;
      else if (b < 8'hf8) c = 3'd3;
      else if (b < 8'hfc) c = 3'd4;
      else if (b < 8'hfe) c = 3'd5;
      else c = CLASS_BAD;
      return c;
    end
  endfunction

endpackage

>>> hdl/fts_classify.sv
// Signature matcher: turns the first sixteen header bytes into a type code.
// Depends on fts_pkg; falls back to the code from the UTF-8 and tar scan.
module fts_classify import fts_pkg::*; (
  input  logic [63:0] w0,
  input  logic [63:0] w1,
  input  logic [6:0]  count,
  input  type_code_t  scan_code,
  output type_code_t  code
);

  logic [31:0] b03;
  logic [15:0] b01;
  logic [31:0] brand;
  logic [63:0] g;
  logic        is_ftyp;
  logic        bmp_size_ok;

  assign b03   = w0[63:32];
  assign b01   = w0[63:48];
  assign brand = w1[63:32];
  assign g     = w0 & 64'hffffffffffff0000;
  assign is_ftyp = (w0 & 64'hffffff00ffffffff) == 64'h0000000066747970;
  assign bmp_size_ok = (|w0[39:16]) || (w0[47:40] >= 8'd26);

  always_comb begin
    code = scan_code;
    if (count < 7'(HEADER_MIN)) begin
      code = scan_code;
    end else if ((b03 & 32'hffffff00) == 32'hffd8ff00) begin
      code = FMT_JPEG;
    end else if (w0 == 64'h89504e470d0a1a0a) begin
      code = FMT_PNG;
    end else if (g == 64'h4749463837610000 || g == 64'h4749463839610000) begin
      code = FMT_GIF;
    end else if (is_ftyp && brand == 32'h71742020) begin
      code = FMT_QT;
    end else if (is_ftyp && (brand == 32'h61766331 || brand == 32'h69736f32 ||
                             brand == 32'h69736f6d || brand == 32'h6d703431 ||
                             brand == 32'h6d703432)) begin
      code = FMT_MP4;
    end else if (is_ftyp && brand == 32'h4d344120) begin
      code = FMT_M4A;
    end else if (is_ftyp && brand == 32'h4d345620) begin
      code = FMT_M4V;
    end else if (is_ftyp && (brand == 32'h33677034 || brand == 32'h33677035 ||
                             brand == 32'h33677036)) begin
      code = FMT_MOBILE;
    end else if (b03 == 32'h1a45dfa3) begin
      code = FMT_MKV;
    end else if ((b01 & 16'hfff6) == 16'hfff2 || (b01 & 16'hfff6) == 16'hfff4 ||
                 (b03 & 32'hffffff00) == 32'h49443300 ||
                 (w0 == 64'd0 && w1 == 64'd0)) begin
      code = FMT_MPA;
    end else if (b03 == 32'h000001ba) begin
      code = FMT_MPV;
    end else if (b03 == 32'h4f676753 && w0[31:24] == 8'd0) begin
      code = FMT_VORBIS;
    end else if (b03 == 32'h52494646 && brand == 32'h57415645) begin
      code = FMT_WAVE;
    end else if (b03 == 32'h52494646 && brand == 32'h41564920) begin
      code = FMT_RIFFVID;
    end else if (w0 == 64'h3026b2758e66cf11 && w1 == 64'ha6d900aa0062ce6c) begin
      code = FMT_ASF;
    end else if (b03 == 32'h504b0304 || b03 == 32'h504b0506 ||
                 b03 == 32'h504b0708) begin
      code = FMT_ZIP;
    end else if (b03 == 32'h52617221) begin
      code = FMT_RAR;
    end else if (b01 == 16'h1f8b) begin
      code = FMT_DEFLATE;
    end else if ((b03 & 32'hfffffff0) == 32'h425a6830) begin
      code = FMT_BLOCKZ;
    end else if (b03 == 32'h25504446) begin
      code = FMT_PDF;
    end else if (w0 == 64'hd0cf11e0a1b11ae1) begin
      code = FMT_DOC;
    end else if (w0 == 64'h41542654464f524d) begin
      code = FMT_DJVU;
    end else if (b01 == 16'h424d && bmp_size_ok) begin
      code = FMT_BITMAP;
    end
  end

endmodule

>>> hdl/file_type_sniffer.sv
// Channel   Signals                                   Carries
// input     in_valid, in_ready, data_byte, last_byte  one file byte per transfer
// output    out_valid, out_ready, type_code           one code per file
// A byte is taken every cycle unless a waiting code holds back a last byte. Each byte
// sits in the input register, where the scan state and header store are updated as it
// leaves; on the last byte the signature match runs in that same cycle and the code is
// registered together with out_valid. A waiting code stalls only a following last byte.
// Reset clears the byte counter, the scan state and both valid flags.
// Top level of the sniffer; depends on fts_pkg and fts_classify.
module file_type_sniffer import fts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] type_code
);

  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_last;
  logic       a_go;

  logic [7:0] hdr_mem [HDR_BYTES];
  logic [6:0] bytes_seen;
  logic [6:0] bytes_seen_next;
  logic [2:0] cont_left;
  logic [2:0] cont_left_next;
  verdict_t   verdict;
  verdict_t   verdict_next;
  logic [2:0] lc;

  logic [7:0] hv [HDR_BYTES];
  logic [63:0] w0;
  logic [63:0] w1;
  type_code_t  scan_code;
  type_code_t  code;

  assign a_go     = a_valid && (!a_last || !out_valid || out_ready);
  assign in_ready = !a_valid || a_go;
  assign lc       = lead_class(a_byte);

  always_comb begin
    cont_left_next = cont_left;
    verdict_next   = verdict;
    case (verdict)
      VERDICT_TEXT: begin
        if (cont_left != 3'd0) begin
          if (a_byte[7:6] != 2'b10) verdict_next = VERDICT_UNKNOWN;
          else cont_left_next = cont_left - 3'd1;
        end else if (lc != CLASS_BAD) begin
          cont_left_next = lc;
        end else if (a_byte != 8'd0) begin
          verdict_next = VERDICT_UNKNOWN;
        end else if (bytes_seen >= 7'(TAR_WINDOW - 1)) begin
          verdict_next = VERDICT_TAR;
        end else begin
          verdict_next = VERDICT_PENDING;
        end
      end
      VERDICT_PENDING: begin
        if (a_byte != 8'd0) verdict_next = VERDICT_UNKNOWN;
        else if (bytes_seen >= 7'(TAR_WINDOW - 1)) verdict_next = VERDICT_TAR;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (verdict_next == VERDICT_TAR) scan_code = FMT_ARCHIVE;
    else if (verdict_next == VERDICT_TEXT && cont_left_next == 3'd0) scan_code = FMT_TEXT;
    else scan_code = FMT_UNKNOWN;
  end

  assign bytes_seen_next = (bytes_seen == COUNT_MAX) ? COUNT_MAX : bytes_seen + 7'd1;

  always_comb begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      if (bytes_seen == 7'(k)) hv[k] = a_byte;
      else if (bytes_seen > 7'(k)) hv[k] = hdr_mem[k];
      else hv[k] = 8'd0;
    end
  end

  assign w0 = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
  assign w1 = {hv[8], hv[9], hv[10], hv[11], hv[12], hv[13], hv[14], hv[15]};

  fts_classify u_classify (
    .w0        (w0),
    .w1        (w1),
    .count     (bytes_seen_next),
    .scan_code (scan_code),
    .code      (code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      bytes_seen <= 7'd0;
      cont_left  <= 3'd0;
      verdict    <= VERDICT_TEXT;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) a_valid <= in_valid;
      if (a_go) begin
        if (a_last) begin
          bytes_seen <= 7'd0;
          cont_left  <= 3'd0;
          verdict    <= VERDICT_TEXT;
        end else begin
          bytes_seen <= bytes_seen_next;
          cont_left  <= cont_left_next;
          verdict    <= verdict_next;
        end
      end
      if (a_go && a_last) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte <= data_byte;
      a_last <= last_byte;
    end
    if (a_go && bytes_seen < 7'(HDR_BYTES)) hdr_mem[bytes_seen[3:0]] <= a_byte;
    if (a_go && a_last) type_code <= code;
  end

endmodule

>>> hdl/fts_checker.sv
// Port-level checks for file_type_sniffer, attached by the bind below.
// Depends on fts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fts_checker import fts_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] data_byte,
  input logic       last_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] type_code
);

  `FTS_ASSERT(code_in_range, out_valid |-> type_code <= FMT_UNKNOWN)
  `FTS_ASSERT(result_held, out_valid && !out_ready |=> out_valid && $stable(type_code))
  `FTS_ASSERT_ALWAYS(reset_clears_output, rst |=> !out_valid)
  `FTS_ASSERT(ready_when_idle, !out_valid |-> in_ready)
  `FTS_ASSERT(input_held, in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(last_byte))

endmodule

bind file_type_sniffer fts_checker u_fts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .data_byte (data_byte),
  .last_byte (last_byte),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .type_code (type_code)
);

>>> bench/tb_file_type_sniffer.sv
// Self-checking bench for file_type_sniffer: files of signature, text, archive and noise bytes
// are streamed through random bursts and receiver stalls, and each type code is predicted.
// Depends on fts_pkg for the type code and scan verdict enumerations and the scan constants.
module tb_file_type_sniffer;
  import fts_pkg::*;

  localparam int STIMULUS_BYTES  = 1600;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CYCLE_LIMIT     = 400000;

  class sniff_board;
    logic [7:0] header_bytes [16];
    int byte_count = 0;
    int cont_left = 0;
    verdict_t verdict = VERDICT_TEXT;
    type_code_t expected_codes[$];
    int errors = 0;
    int files_seen = 0;
    int codes_checked = 0;
    bit [25:0] codes_covered = '0;

    task report_mismatch(string what);
      $display("MISMATCH %s", what);
      errors++;
    endtask

    function int utf8_tail_len(logic [7:0] b);
      if (b == 8'h09 || b == 8'h0a || b == 8'h0d) return 0;
      if (b < 8'h20 || b == 8'h7f) return -1;
      casez (b)
        8'b0???????: return 0;
        8'b110?????: return 1;
        8'b1110????: return 2;
        8'b11110???: return 3;
        8'b111110??: return 4;
        8'b1111110?: return 5;
        default: return -1;
      endcase
    endfunction

    function logic [7:0] header_byte(int k);
      return (k < byte_count && k < 16) ? header_bytes[k] : 8'h00;
    endfunction

    function type_code_t scan_outcome();
      if (verdict == VERDICT_TAR) return FMT_ARCHIVE;
      if (verdict == VERDICT_TEXT && cont_left == 0) return FMT_TEXT;
      return FMT_UNKNOWN;
    endfunction

    function type_code_t classify_file();
      logic [63:0] w0;
      logic [63:0] w1;
      logic [31:0] b03;
      logic [31:0] brand;
      logic [31:0] bmp_size;
      logic [15:0] b01;
      w0 = '0;
      w1 = '0;
      if (byte_count < HEADER_MIN) return scan_outcome();
      for (int k = 0; k < 8; k++) begin
        w0 = {w0[55:0], header_byte(k)};
        w1 = {w1[55:0], header_byte(k + 8)};
      end
      b03 = w0[63:32];
      b01 = w0[63:48];
      brand = w1[63:32];
      bmp_size = {header_byte(5), header_byte(4), header_byte(3), header_byte(2)};
      if ((b03 & 32'hffffff00) == 32'hffd8ff00) return FMT_JPEG;
      if (w0 == 64'h89504e470d0a1a0a) return FMT_PNG;
      if ((w0 & 64'hffffffffffff0000) == 64'h4749463837610000 ||
          (w0 & 64'hffffffffffff0000) == 64'h4749463839610000) return FMT_GIF;
      if ((w0 & 64'hffffff00ffffffff) == 64'h0000000066747970) begin
        case (brand)
          32'h71742020: return FMT_QT;
          32'h61766331, 32'h69736f32, 32'h69736f6d, 32'h6d703431, 32'h6d703432: return FMT_MP4;
          32'h4d344120: return FMT_M4A;
          32'h4d345620: return FMT_M4V;
          32'h33677034, 32'h33677035, 32'h33677036: return FMT_MOBILE;
          default: ;
        endcase
      end
      if (b03 == 32'h1a45dfa3) return FMT_MKV;
      if ((b01 & 16'hfff6) == 16'hfff2 || (b01 & 16'hfff6) == 16'hfff4 ||
          (b03 & 32'hffffff00) == 32'h49443300 || (w0 == '0 && w1 == '0)) return FMT_MPA;
      if (b03 == 32'h000001ba) return FMT_MPV;
      if (b03 == 32'h4f676753 && header_byte(4) == 8'h00) return FMT_VORBIS;
      if (b03 == 32'h52494646) begin
        if (brand == 32'h57415645) return FMT_WAVE;
        if (brand == 32'h41564920) return FMT_RIFFVID;
      end
      if (w0 == 64'h3026b2758e66cf11 && w1 == 64'ha6d900aa0062ce6c) return FMT_ASF;
      if (b03 == 32'h504b0304 || b03 == 32'h504b0506 || b03 == 32'h504b0708) return FMT_ZIP;
      if (b03 == 32'h52617221) return FMT_RAR;
      if (b01 == 16'h1f8b) return FMT_DEFLATE;
      if ((b03 & 32'hfffffff0) == 32'h425a6830) return FMT_BLOCKZ;
      if (b03 == 32'h25504446) return FMT_PDF;
      if (w0 == 64'hd0cf11e0a1b11ae1) return FMT_DOC;
      if (w0 == 64'h41542654464f524d) return FMT_DJVU;
      if (b01 == 16'h424d && bmp_size >= 32'd26) return FMT_BITMAP;
      return scan_outcome();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int pos;
      int tail;
      pos = byte_count;
      case (verdict)
        VERDICT_TEXT: begin
          if (cont_left != 0) begin
            if (b[7:6] != 2'b10) verdict = VERDICT_UNKNOWN;
            else cont_left--;
          end else begin
            tail = utf8_tail_len(b);
            if (tail >= 0) cont_left = tail;
            else if (b != 8'h00) verdict = VERDICT_UNKNOWN;
            else verdict = (pos >= TAR_WINDOW - 1) ? VERDICT_TAR : VERDICT_PENDING;
          end
        end
        VERDICT_PENDING: begin
          if (b != 8'h00) verdict = VERDICT_UNKNOWN;
          else if (pos >= TAR_WINDOW - 1) verdict = VERDICT_TAR;
        end
        default: ;
      endcase
      if (pos < 16) header_bytes[pos] = b;
      if (byte_count < int'(COUNT_MAX)) byte_count++;
      if (last) begin
        expected_codes.push_back(classify_file());
        files_seen++;
        byte_count = 0;
        cont_left = 0;
        verdict = VERDICT_TEXT;
      end
    endfunction

    task check_code(logic [4:0] got);
      type_code_t want;
      if (expected_codes.size() == 0) begin
        report_mismatch($sformatf("type code %0d arrived with no file outstanding", got));
      end else begin
        want = expected_codes.pop_front();
        codes_covered[want] = 1'b1;
        if (got !== want)
          report_mismatch($sformatf("file %0d: type code %0d, expected %0d (%s)",
                                    codes_checked, got, want, want.name()));
        codes_checked++;
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] type_code;

  sniff_board board;
  logic [7:0] file_bytes[$];
  int burst_left = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  file_type_sniffer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .type_code(type_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_byte(data_byte, last_byte);
      if (out_valid && out_ready) board.check_code(type_code);
    end
  end

  function automatic void push_word(logic [63:0] w, int n);
    for (int i = n - 1; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void push_random_bytes(int target);
    while (file_bytes.size() < target) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void push_text_bytes(int target);
    int tail;
    while (file_bytes.size() < target) begin
      case ($urandom_range(0, 15))
        0: begin
          case ($urandom_range(0, 2))
            0: file_bytes.push_back(8'h09);
            1: file_bytes.push_back(8'h0a);
            default: file_bytes.push_back(8'h0d);
          endcase
        end
        1, 2, 3, 4, 5, 6, 7, 8, 9: file_bytes.push_back(8'($urandom_range(32, 126)));
        default: begin
          tail = $urandom_range(1, 5);
          case (tail)
            1: file_bytes.push_back(8'hc0 + 8'($urandom_range(0, 31)));
            2: file_bytes.push_back(8'he0 + 8'($urandom_range(0, 15)));
            3: file_bytes.push_back(8'hf0 + 8'($urandom_range(0, 7)));
            4: file_bytes.push_back(8'hf8 + 8'($urandom_range(0, 3)));
            default: file_bytes.push_back(8'hfc + 8'($urandom_range(0, 1)));
          endcase
          repeat (tail) file_bytes.push_back(8'h80 + 8'($urandom_range(0, 63)));
        end
      endcase
    end
  endfunction

  task automatic send_file();
    int gap;
    for (int i = 0; i < file_bytes.size(); i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 48);
      end
      in_valid <= 1'b1;
      data_byte <= file_bytes[i];
      last_byte <= (i == file_bytes.size() - 1);
      @(posedge clk);
      while (in_ready !== 1'b1) @(posedge clk);
      burst_left--;
      bytes_sent++;
    end
  endtask

  initial begin
    int mode;
    int seg_len;
    int segs;
    segs = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (segs == 12) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      seg_len = $urandom_range(4, 50);
      repeat (seg_len) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= 1'b0;
        endcase
        @(posedge clk);
      end
      segs++;
    end
  end

  initial begin
    int kind;
    int target;
    int trunc;
    logic [31:0] brand_word;
    board = new;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Single-byte files, a split character and the BMP size boundary on short headers.
    file_bytes.delete(); push_word(8'h41, 1); send_file();
    file_bytes.delete(); push_word(8'h00, 1); send_file();
    file_bytes.delete(); push_word(8'hff, 1); send_file();
    file_bytes.delete(); push_word(8'hc3, 1); send_file();
    file_bytes.delete(); push_word(16'hc3a9, 2); send_file();
    file_bytes.delete(); push_word(64'h424d1a0000004141, 8); send_file();
    file_bytes.delete(); push_word(64'h424d190000004141, 8); send_file();

    while (bytes_sent < STIMULUS_BYTES) begin
      file_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        target = $urandom_range(8, 20);
        case ($urandom_range(0, 19))
          0: push_word(24'hffd8ff, 3);
          1: push_word(64'h89504e470d0a1a0a, 8);
          2: begin
            push_word(32'h47494638, 4);
            file_bytes.push_back(($urandom_range(0, 1) == 1) ? 8'h37 : 8'h39);
            file_bytes.push_back(8'h61);
          end
          3: begin
            push_word(24'h000000, 3);
            file_bytes.push_back(8'($urandom));
            push_word(32'h66747970, 4);
            case ($urandom_range(0, 12))
              0: brand_word = 32'h71742020;
              1: brand_word = 32'h61766331;
              2: brand_word = 32'h69736f32;
              3: brand_word = 32'h69736f6d;
              4: brand_word = 32'h6d703431;
              5: brand_word = 32'h6d703432;
              6: brand_word = 32'h4d344120;
              7: brand_word = 32'h4d345620;
              8: brand_word = 32'h33677034;
              9: brand_word = 32'h33677035;
              10: brand_word = 32'h33677036;
              default: brand_word = $urandom;
            endcase
            push_word(brand_word, 4);
          end
          4: push_word(32'h1a45dfa3, 4);
          5: begin
            file_bytes.push_back(8'hff);
            file_bytes.push_back((($urandom_range(0, 1) == 1) ? 8'hf2 : 8'hf4) |
                                 (8'($urandom) & 8'h09));
          end
          6: push_word(24'h494433, 3);
          7: begin
            push_word(64'h0, 8);
            push_word(64'h0, 8);
          end
          8: push_word(32'h000001ba, 4);
          9: begin
            push_word(32'h4f676753, 4);
            file_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
          end
          10: begin
            push_word(32'h52494646, 4);
            push_word(64'($urandom), 4);
            case ($urandom_range(0, 2))
              0: push_word(32'h57415645, 4);
              1: push_word(32'h41564920, 4);
              default: push_word(64'($urandom), 4);
            endcase
          end
          11: begin
            push_word(64'h3026b2758e66cf11, 8);
            push_word(64'ha6d900aa0062ce6c, 8);
          end
          12: begin
            case ($urandom_range(0, 2))
              0: push_word(32'h504b0304, 4);
              1: push_word(32'h504b0506, 4);
              default: push_word(32'h504b0708, 4);
            endcase
          end
          13: push_word(32'h52617221, 4);
          14: push_word(16'h1f8b, 2);
          15: begin
            push_word(24'h425a68, 3);
            file_bytes.push_back(8'h30 + 8'($urandom_range(0, 15)));
          end
          16: push_word(32'h25504446, 4);
          17: push_word(64'hd0cf11e0a1b11ae1, 8);
          18: push_word(64'h41542654464f524d, 8);
          default: begin
            push_word(16'h424d, 2);
            if ($urandom_range(0, 1) == 1) begin
              file_bytes.push_back(8'($urandom_range(22, 30)));
              push_word(24'h000000, 3);
            end else begin
              push_word(64'($urandom), 4);
            end
          end
        endcase
        trunc = $urandom_range(0, 7);
        if (trunc == 0) begin
          target = $urandom_range(1, 7);
          while (file_bytes.size() > target) void'(file_bytes.pop_back());
        end else begin
          if (trunc == 1) target = $urandom_range(20, 60);
          if ($urandom_range(0, 1) == 1) push_text_bytes(target);
          else push_random_bytes(target);
        end
      end else if (kind < 72) begin
        push_text_bytes($urandom_range(1, 24));
        case ($urandom_range(0, 5))
          0, 1: file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
          2: file_bytes.push_back(8'he2);
          default: ;
        endcase
      end else if (kind < 77) begin
        if ($urandom_range(0, 3) == 0) begin
          push_text_bytes(TAR_WINDOW - 1);
          file_bytes.push_back(8'h00);
          push_random_bytes(file_bytes.size() + $urandom_range(0, 20));
        end else begin
          push_text_bytes($urandom_range(1, 30));
          target = $urandom_range(TAR_WINDOW - 8, TAR_WINDOW + 30);
          while (file_bytes.size() < target) file_bytes.push_back(8'h00);
          if ($urandom_range(0, 4) == 0)
            file_bytes[$urandom_range(file_bytes.size() / 2, file_bytes.size() - 1)] =
              8'($urandom_range(1, 255));
        end
      end else if (kind < 90) begin
        if ($urandom_range(0, 1) == 1) push_text_bytes($urandom_range(1, 15));
        else push_random_bytes($urandom_range(1, 15));
      end else begin
        push_random_bytes($urandom_range(1, 40));
      end
      send_file();
    end
    in_valid <= 1'b0;

    while (board.expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d files in %0d bytes; %0d of 26 type codes were expected at least once.",
             board.files_seen, bytes_sent, $countones(board.codes_covered));
    $display("Receiver held off for %0d cycles once; %0d mismatches.",
             HOLD_OFF_CYCLES, board.errors);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
